// ===== hdl/weighted_score_cache_replacement_defines.svh =====
// Assertion macros for the weighted score replacement block.
`ifndef WEIGHTED_SCORE_CACHE_REPLACEMENT_DEFINES_SVH
`define WEIGHTED_SCORE_CACHE_REPLACEMENT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define WSCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WSCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/wscr_pkg.sv =====
// Shared types, constants and functions of the weighted score replacement block.
package wscr_pkg;
  localparam int SETS = 2048;
  localparam int WAYS = 16;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int ENT_W = SET_W + WAY_W;
  localparam int ENTRIES = SETS * WAYS;
  // way entry: age, use count, page group, stamp
  localparam int WENT_W = 4 + 4 + 16 + 64;
  // set entry: spatial, frequent, recent, choice, window start
  localparam int SENT_W = 32 * 3 + 2 + 64;
  localparam logic [31:0] STAT_CAP = 32'hFFFF_FFFF;

  localparam logic [1:0] CFG_PHASE_WINDOW = 2'd0;
  localparam logic [1:0] CFG_FREQ_THRESH = 2'd1;
  localparam logic [1:0] CFG_RECENT_DEPTH = 2'd2;

  // request kinds
  localparam logic ACT_VICTIM = 1'b0;
  localparam logic ACT_ACCESS = 1'b1;

  typedef struct packed {
    logic [3:0]  age;
    logic [3:0]  cnt;
    logic [15:0] page;
    logic [63:0] stamp;
  } way_ent_t;

  typedef struct packed {
    logic [31:0] sp;
    logic [31:0] fr;
    logic [31:0] rc;
    logic [1:0]  choice;
    logic [63:0] wstart;
  } set_ent_t;

  // weight triple in tenths: recency, frequency, page
  function automatic logic [11:0] weights(input logic [1:0] c);
    case (c)
      2'd0: weights = {4'd5, 4'd3, 4'd2};
      2'd1: weights = {4'd2, 4'd3, 4'd5};
      2'd2: weights = {4'd2, 4'd6, 4'd2};
      default: weights = {4'd7, 4'd2, 4'd1};
    endcase
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] v);
    bump = (v != STAT_CAP) ? v + 32'd1 : v;
  endfunction
endpackage

// ===== hdl/weighted_score_cache_replacement.sv =====
// Weighted score replacement: victim search and access recording, one way per cycle.
// Victim: read sweep of the set, then scoring of one way a cycle; the next item is taken
// the cycle after the result leaves.
// Access report: read sweep, then write-back sweep; not ready meanwhile.
// After reset a clearing pass over all SETS*WAYS entries initializes the RAMs; no item taken then.
// Reset (rst_n, synchronous): config registers to 4096, 8, 4; access clock to zero.
module weighted_score_cache_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: action[0], set_index[11:1], way_index[15:12], phys_address[79:16], was_hit[80]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: evict_way[3:0]
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import wscr_pkg::*;
  `include "weighted_score_cache_replacement_defines.svh"

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_SRD  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_SCR  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [31:0] pw_r;
  logic [3:0] ft_r;
  logic [4:0] rd_r;
  logic [63:0] clock_r;
  logic [ENT_W-1:0] clr_r;
  logic [WAY_W:0] k_r;
  logic act_r, hit_r;
  logic [SET_W-1:0] set_r;
  logic [WAY_W-1:0] way_r, vic_r;
  logic [15:0] page_r;
  logic [63:0] best_r;
  way_ent_t ents_r [WAYS];
  set_ent_t sent_r;
  logic [11:0] wts_r;

  // RAM ports
  logic w_we, s_we;
  logic [ENT_W-1:0] w_addr;
  way_ent_t w_wd, w_rd;
  set_ent_t s_wd, s_rd;

  wscr_ram #(.WIDTH(WENT_W), .DEPTH(ENTRIES)) u_way (
    .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wd), .rdata(w_rd));
  wscr_ram #(.WIDTH(SENT_W), .DEPTH(SETS)) u_set (
    .clk(clk), .we(s_we), .addr(clr_r[ENT_W-1:WAY_W] & {SET_W{st_r == S_CLR}}
      | set_r & {SET_W{st_r != S_CLR}}), .wdata(s_wd), .rdata(s_rd));

  // way scored in this cycle lags the step count by one
  logic [WAY_W-1:0] scr_k;
  assign scr_k = k_r[WAY_W-1:0] - WAY_W'(1);

  logic [63:0] score;
  wscr_score u_score (.wts(wts_r), .ent(ents_r[scr_k]), .page(page_r),
    .clock(clock_r), .score(score));

  logic [3:0] old_age, new_cnt;
  logic repick;
  logic [1:0] nchoice;
  always_comb begin
    old_age = ents_r[way_r].age;
    new_cnt = hit_r ? ((ents_r[way_r].cnt != 4'd15) ? ents_r[way_r].cnt + 4'd1
      : ents_r[way_r].cnt) : {1'b0, ents_r[way_r].cnt[3:1]};
    repick = (clock_r - sent_r.wstart) > {32'd0, pw_r};
    if (sent_r.sp > sent_r.fr && sent_r.sp > sent_r.rc) nchoice = 2'd1;
    else if (sent_r.fr > sent_r.sp && sent_r.fr > sent_r.rc) nchoice = 2'd2;
    else nchoice = 2'd3;
  end

  // RAM control
  always_comb begin
    w_we = 1'b0; s_we = 1'b0;
    w_addr = {set_r, k_r[WAY_W-1:0]};
    w_wd = ents_r[k_r[WAY_W-1:0]];
    s_wd = sent_r;
    case (st_r)
      S_CLR: begin
        w_we = 1'b1; s_we = (clr_r[WAY_W-1:0] == '0);
        w_addr = clr_r[ENT_W-1:0];
        w_wd = '{age: clr_r[WAY_W-1:0], cnt: 4'd0, page: 16'd0, stamp: 64'd0};
        s_wd = '0;
      end
      S_IDLE: w_addr = {in_tdata[SET_W:1], {WAY_W{1'b0}}};
      S_RD: w_addr = {set_r, k_r[WAY_W-1:0] + WAY_W'(1)};
      S_WR: begin
        w_we = 1'b1;
        if (k_r[WAY_W-1:0] == way_r)
          w_wd = '{age: 4'd0, cnt: new_cnt, page: page_r, stamp: clock_r};
        else if (ents_r[k_r[WAY_W-1:0]].age < old_age)
          w_wd.age = ents_r[k_r[WAY_W-1:0]].age + 4'd1;
        if (k_r == '0) begin
          s_we = hit_r;
          if (ents_r[way_r].page == page_r) s_wd.sp = bump(sent_r.sp);
          if (new_cnt > ft_r) s_wd.fr = bump(sent_r.fr);
          if ({1'b0, old_age} < rd_r) s_wd.rc = bump(sent_r.rc);
        end
      end
      S_SCR: if (k_r == '0 && repick) begin
        s_we = 1'b1;
        s_wd = '{sp: 32'd0, fr: 32'd0, rc: 32'd0, choice: nchoice, wstart: clock_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    in_tready = (st_r == S_IDLE);
    cfg_ready = 1'b1;
    out_tvalid = (st_r == S_OUT);
    out_tdata = {4'd0, vic_r};
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLR: if (clr_r == ENT_W'(ENTRIES - 1)) st_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) begin
        if (in_tdata[0] == ACT_ACCESS && {1'b0, in_tdata[15:12]} >= (WAY_W+1)'(WAYS))
          st_nxt = S_IDLE;
        else st_nxt = S_SRD;
      end
      S_SRD: st_nxt = S_RD;
      S_RD: if (k_r == (WAY_W+1)'(WAYS - 1)) st_nxt = (act_r == ACT_ACCESS) ? S_WR : S_SCR;
      S_SCR: if (k_r == (WAY_W+1)'(WAYS)) st_nxt = S_OUT;
      S_WR: if (k_r == (WAY_W+1)'(WAYS - 1)) st_nxt = S_IDLE;
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; clock_r <= '0;
      pw_r <= 32'd4096; ft_r <= 4'd8; rd_r <= 5'd4; k_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PHASE_WINDOW: pw_r <= cfg_data;
          CFG_FREQ_THRESH: ft_r <= cfg_data[3:0];
          CFG_RECENT_DEPTH: rd_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (st_r)
        S_CLR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (in_tvalid) begin
          clock_r <= clock_r + 64'd1;
          act_r <= in_tdata[0]; set_r <= in_tdata[SET_W:1];
          way_r <= in_tdata[15:12]; page_r <= in_tdata[43:28];
          hit_r <= in_tdata[80]; k_r <= '0;
        end
        S_SRD: ;
        S_RD: begin
          ents_r[k_r[WAY_W-1:0]] <= w_rd;
          if (k_r == '0) begin
            sent_r <= s_rd;
          end
          k_r <= (k_r == (WAY_W+1)'(WAYS - 1)) ? '0 : k_r + 1'b1;
        end
        S_SCR: begin
          if (k_r == '0) begin
            if (repick) wts_r <= weights(nchoice); else wts_r <= weights(sent_r.choice);
          end else if (k_r == (WAY_W+1)'(1) || score < best_r) begin
            best_r <= score; vic_r <= scr_k;
          end
          k_r <= k_r + 1'b1;
        end
        S_WR: k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  // scoring: step k uses ents_r[k-1]; weights latched at k==0
  `WSCR_ASSERT_IMPL(a_out_only_victim, out_tvalid, !in_tready)
  `WSCR_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready && in_tdata[0] == ACT_VICTIM, !in_tready)
  `WSCR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

// ===== hdl/wscr_ram.sv =====
// Generic single-port RAM with registered read.
module wscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/wscr_score.sv =====
// Score of one way: weighted recency, infrequency, page mismatch and age.
module wscr_score (
  input  logic [11:0]  wts,
  input  wscr_pkg::way_ent_t ent,
  input  logic [15:0]  page,
  input  logic [63:0]  clock,
  output logic [63:0]  score
);
  import wscr_pkg::*;
  logic [63:0] age_t;
  logic [31:0] age_c;
  logic [63:0] t0, t1, t2, t3;
  always_comb begin
    age_t = clock - ent.stamp;
    age_c = (age_t[63:32] != 32'd0) ? 32'hFFFF_FFFF : age_t[31:0];
    t0 = 64'(wts[11:8]) * 64'(ent.age) * 64'(15 * 409600);
    t1 = 64'(wts[7:4]) * 64'(4'd15 - ent.cnt) * 64'(WAYS * 409600);
    t2 = (ent.page != page) ? 64'(wts[3:0]) * 64'(15 * WAYS * 409600) : 64'd0;
    t3 = 64'(age_c) * 64'(150 * WAYS);
    score = t0 + t1 + t2 + t3;
  end
endmodule

// ===== verif/tb_weighted_score_cache_replacement.sv =====
// Self-checking testbench of the weighted score replacement block: directed rows, then random traffic.
module tb_weighted_score_cache_replacement;
  import wscr_pkg::*;

  localparam int LATENCY = 2 + 2 * WAYS + 16;
  localparam int WDOG_LIMIT = 200000;
  localparam int N_RANDOM_PHASE = 160;
  localparam int NO_RESULT = -1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  weighted_score_cache_replacement u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    bit        act;
    bit [10:0] set;
    bit [3:0]  way;
    bit [63:0] addr;
    bit        hit;
    int        want;  // typed-in victim, or NO_RESULT to use the model
  } req_t;

  // shadow state of the replacement policy
  bit [3:0]  sh_age [ENTRIES];
  bit [3:0]  sh_cnt [ENTRIES];
  bit [15:0] sh_page [ENTRIES];
  bit [63:0] sh_stamp [ENTRIES];
  bit [63:0] sh_clock;
  bit [31:0] sh_sp [SETS];
  bit [31:0] sh_fr [SETS];
  bit [31:0] sh_rc [SETS];
  bit [1:0]  sh_choice [SETS];
  bit [63:0] sh_wstart [SETS];
  bit [31:0] sh_window;
  bit [3:0]  sh_thresh;
  bit [4:0]  sh_depth;
  int        wtab [4][3] = '{'{5, 3, 2}, '{2, 3, 5}, '{2, 6, 2}, '{7, 2, 1}};

  bit [3:0]  victim_q [$];
  int        mismatches = 0;
  int        idle_cnt = 0;
  bit        failed = 1'b0;
  bit        hold_rx = 1'b0;
  bit        quiet_tx = 1'b0;
  longint    cyc = 0;
  req_t      dir_rows [16];

  function automatic bit [31:0] sat_inc(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // choose the way with lowest weighted score, re-picking weights when the window ran out
  function automatic bit [3:0] choose_victim(int s, bit [63:0] addr);
    bit [15:0] pg;
    longint unsigned best, sc, aget;
    bit [3:0] vic;
    int c, e;
    pg = addr[27:12];
    best = 0;
    vic = 0;
    if (sh_clock - sh_wstart[s] > {32'd0, sh_window}) begin
      if (sh_sp[s] > sh_fr[s] && sh_sp[s] > sh_rc[s]) sh_choice[s] = 2'd1;
      else if (sh_fr[s] > sh_sp[s] && sh_fr[s] > sh_rc[s]) sh_choice[s] = 2'd2;
      else sh_choice[s] = 2'd3;
      sh_sp[s] = 0;
      sh_fr[s] = 0;
      sh_rc[s] = 0;
      sh_wstart[s] = sh_clock;
    end
    c = sh_choice[s];
    for (int k = 0; k < WAYS; k++) begin
      e = s * WAYS + k;
      aget = sh_clock - sh_stamp[e];
      if (aget > 64'hFFFF_FFFF) aget = 64'hFFFF_FFFF;
      sc = longint'(wtab[c][0]) * sh_age[e] * 15 * 409600
         + longint'(wtab[c][1]) * (15 - sh_cnt[e]) * WAYS * 409600
         + ((sh_page[e] != pg) ? longint'(wtab[c][2]) * 15 * WAYS * 409600 : 0)
         + aget * 150 * WAYS;
      if (k == 0 || sc < best) begin
        best = sc;
        vic = k[3:0];
      end
    end
    return vic;
  endfunction

  // move way to MRU, adjust use count, store page and stamp, gather hit statistics
  function automatic void record_use(int s, int w, bit [63:0] addr, bit hit);
    int e;
    bit [3:0] old_age;
    bit [15:0] pg;
    bit same;
    e = s * WAYS + w;
    old_age = sh_age[e];
    pg = addr[27:12];
    same = (sh_page[e] == pg);
    for (int k = 0; k < WAYS; k++)
      if (sh_age[s * WAYS + k] < old_age) sh_age[s * WAYS + k]++;
    sh_age[e] = 0;
    if (hit) begin
      if (sh_cnt[e] != 4'd15) sh_cnt[e]++;
    end else begin
      sh_cnt[e] = sh_cnt[e] >> 1;
    end
    sh_page[e] = pg;
    sh_stamp[e] = sh_clock;
    if (hit) begin
      if (same) sh_sp[s] = sat_inc(sh_sp[s]);
      if (sh_cnt[e] > sh_thresh) sh_fr[s] = sat_inc(sh_fr[s]);
      if ({1'b0, old_age} < sh_depth) sh_rc[s] = sat_inc(sh_rc[s]);
    end
  endfunction

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted items, then choose next ready
  initial begin : rx
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (victim_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected victim %0d", out_tdata[3:0]);
        end else begin
          if (out_tdata[3:0] !== victim_q[0]) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("victim mismatch: expected %0d got %0d", victim_q[0], out_tdata[3:0]);
          end
          void'(victim_q.pop_front());
        end
      end
      if (hold_rx && stall == 0) begin
        stall = 300;
        hold_rx = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (cyc > 45000 && cyc < 50000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_WINDOW: sh_window = val;
      CFG_FREQ_THRESH:  sh_thresh = val[3:0];
      default:          sh_depth = val[4:0];
    endcase
  endtask

  // offer one item; valid stays high into the next item unless an idle gap follows
  task automatic send(req_t r);
    bit [3:0] v;
    if (!quiet_tx && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tdata <= {7'd0, r.hit, r.addr, r.way, r.set, r.act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sh_clock = sh_clock + 1;
    if (r.act == ACT_VICTIM) begin
      v = choose_victim(r.set, r.addr);
      victim_q.push_back((r.want == NO_RESULT) ? v : r.want[3:0]);
    end else begin
      record_use(r.set, r.way, r.addr, r.hit);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic req_t rand_req();
    req_t r;
    bit [10:0] pool [6] = '{11'd0, 11'd1, 11'd5, 11'd300, 11'd1024, 11'd2047};
    r.addr = {$urandom, $urandom};
    r.way = 4'($urandom_range(15));
    r.act = ($urandom_range(99) < 55) ? ACT_ACCESS : ACT_VICTIM;
    r.hit = ($urandom_range(99) < 70);
    r.want = NO_RESULT;
    if ($urandom_range(99) < 75) begin
      r.set = pool[$urandom_range(5)];
      r.addr[27:12] = 16'(16'h1234 + $urandom_range(3));
    end else begin
      r.set = 11'($urandom);
    end
    return r;
  endfunction

  initial begin : main
    for (int e = 0; e < ENTRIES; e++) begin
      sh_age[e] = 4'(e % WAYS);
      sh_cnt[e] = 0;
      sh_page[e] = 0;
      sh_stamp[e] = 0;
    end
    for (int s = 0; s < SETS; s++) begin
      sh_sp[s] = 0; sh_fr[s] = 0; sh_rc[s] = 0; sh_choice[s] = 0; sh_wstart[s] = 0;
    end
    sh_clock = 0;
    sh_window = 32'd4096;
    sh_thresh = 4'd8;
    sh_depth = 5'd4;

    // act, set, way, addr, hit, victim
    dir_rows = '{
      '{ACT_VICTIM, 11'd0,    4'd0,  64'd0,  1'b0, 0},
      '{ACT_VICTIM, 11'd2047, 4'd0,  '1,     1'b1, 0},
      '{ACT_ACCESS, 11'd0,    4'd15, '1,     1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd0,    4'd0,  64'd0,  1'b0, NO_RESULT},
      '{ACT_VICTIM, 11'd0,    4'd0,  '1,     1'b0, NO_RESULT},
      '{ACT_ACCESS, 11'd0,    4'd3,  64'h5000, 1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd0,    4'd3,  64'h5000, 1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd0,    4'd3,  64'h5fff, 1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd0,    4'd3,  64'h5000, 1'b0, NO_RESULT},
      '{ACT_VICTIM, 11'd0,    4'd9,  64'h5000, 1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd2047, 4'd0,  '1,     1'b1, NO_RESULT},
      '{ACT_ACCESS, 11'd2047, 4'd15, 64'd0,  1'b0, NO_RESULT},
      '{ACT_VICTIM, 11'd2047, 4'd15, 64'd0,  1'b0, NO_RESULT},
      '{ACT_ACCESS, 11'd1,    4'd7,  64'hFFFF_FFFF_F000_0FFF, 1'b1, NO_RESULT},
      '{ACT_VICTIM, 11'd1,    4'd0,  64'h0FFF_F000, 1'b0, NO_RESULT},
      '{ACT_VICTIM, 11'd1,    4'd0,  64'hFFFF_FFFF_F000_0FFF, 1'b1, NO_RESULT}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // defaults from reset, directed rows
    foreach (dir_rows[i]) send(dir_rows[i]);
    drain();

    // receiver holds off long while items keep coming
    hold_rx = 1'b1;
    for (int i = 0; i < N_RANDOM_PHASE; i++) send(rand_req());
    drain();

    // window of one, lowest threshold, deepest recency
    write_reg(CFG_PHASE_WINDOW, 32'd1);
    write_reg(CFG_FREQ_THRESH, 4'd0);
    write_reg(CFG_RECENT_DEPTH, 5'd16);
    quiet_tx = 1'b1;
    for (int i = 0; i < N_RANDOM_PHASE; i++) send(rand_req());
    quiet_tx = 1'b0;
    drain();

    // widest window, highest threshold, no recency
    write_reg(CFG_PHASE_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_FREQ_THRESH, 4'd15);
    write_reg(CFG_RECENT_DEPTH, 5'd0);
    for (int i = 0; i < N_RANDOM_PHASE / 2; i++) send(rand_req());
    drain();

    // middle settings with frequent re-picks
    write_reg(CFG_PHASE_WINDOW, 32'd20);
    write_reg(CFG_FREQ_THRESH, 4'd3);
    write_reg(CFG_RECENT_DEPTH, 5'd8);
    for (int i = 0; i < N_RANDOM_PHASE / 2; i++) send(rand_req());
    drain();

    if (!failed && mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
